// ----- src/mbet_pkg.sv -----
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types, widths and helpers for the Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package mbet_pkg;

  // Field and datapath widths
  localparam int WORD_W        = 32;
  localparam int PROD_W        = 2 * WORD_W;
  localparam int COORD_W       = 10;
  localparam int ITER_W        = 8;
  localparam int SPACING_W     = 31;
  localparam int OFFSET_W      = 10;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 26;
  localparam int QUEUE_DEPTH   = 2;

  // Reset values of the configuration registers
  localparam int SPACING_DIV = 200;  // spacing resets to 1/200 of one unit
  localparam int OFFSET_RST  = 400;
  localparam int ITER_RST    = 50;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPACING   = 3'd0,
    REG_RE_CENTRE = 3'd1,
    REG_IM_CENTRE = 3'd2,
    REG_OFFSET    = 3'd3,
    REG_MAX_ITER  = 3'd4
  } cfg_reg_e;

  // Current configuration, handed to both halves
  typedef struct packed {
    logic [SPACING_W-1:0]     spacing;
    logic signed [WORD_W-1:0] re_centre;
    logic signed [WORD_W-1:0] im_centre;
    logic [OFFSET_W-1:0]      origin_offset;
    logic [ITER_W-1:0]        max_iter;
  } cfg_t;

  // A mapped point waiting in the queue
  typedef struct packed {
    logic [COORD_W-1:0]       column;
    logic [COORD_W-1:0]       row;
    logic signed [WORD_W-1:0] c_re;
    logic signed [WORD_W-1:0] c_im;
  } point_t;

  // Iteration engine states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_DONE
  } back_state_e;

  // Clamp a wide signed value to the signed word range
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    if (v[PROD_W-1:WORD_W-1] == '0 || v[PROD_W-1:WORD_W-1] == '1) begin
      return v[WORD_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

// ----- src/mbet_if.sv -----
// ----------------------------------------------------------------------------
// mbet_in_if / mbet_out_if
// Valid/ready channels for pixel items and result items.
// ----------------------------------------------------------------------------
interface mbet_in_if import mbet_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

interface mbet_out_if import mbet_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_column;
  logic [COORD_W-1:0] out_row;
  logic [ITER_W-1:0]  iterations;
  logic               inside_res;

  modport source (output valid, output out_column, output out_row, output iterations,
                  output inside_res, input ready);
  modport sink   (input valid, input out_column, input out_row, input iterations,
                  input inside_res, output ready);
endinterface

// ----- src/mbet_front.sv -----
// ----------------------------------------------------------------------------
// mbet_front
// Accepts pixel items and maps them to points in the complex plane.
// ----------------------------------------------------------------------------
module mbet_front import mbet_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  mbet_in_if.sink pixel,
  output point_t push_data,
  output logic   push_valid,
  input  logic   push_ready
);

  // (index - offset) is 11 bits signed, spacing 32 bits signed
  localparam int MAP_W = COORD_W + 1 + SPACING_W + 1;

  logic                     hold_valid;
  logic [COORD_W-1:0]       col_q;
  logic [COORD_W-1:0]       row_q;
  logic signed [MAP_W-1:0]  re_prod;
  logic signed [MAP_W-1:0]  im_prod;
  logic signed [COORD_W:0]  d_col;
  logic signed [COORD_W:0]  d_row;
  logic signed [WORD_W-1:0] spacing_s;
  logic signed [MAP_W-1:0]  re_prod_next;
  logic signed [MAP_W-1:0]  im_prod_next;

  // One holding stage, drained straight into the queue
  assign pixel.ready = !hold_valid || push_ready;
  assign push_valid  = hold_valid;

  // Offset pixel indexes and scale by spacing
  always_comb begin
    d_col        = $signed({1'b0, pixel.column}) - $signed({1'b0, cfg.origin_offset});
    d_row        = $signed({1'b0, pixel.row}) - $signed({1'b0, cfg.origin_offset});
    spacing_s    = $signed({1'b0, cfg.spacing});
    re_prod_next = MAP_W'(d_col) * MAP_W'(spacing_s);
    im_prod_next = MAP_W'(d_row) * MAP_W'(spacing_s);
  end

  // Subtract centre and clamp
  always_comb begin
    push_data.column = col_q;
    push_data.row    = row_q;
    push_data.c_re   = sat_word(PROD_W'(re_prod) - PROD_W'($signed(cfg.re_centre)));
    push_data.c_im   = sat_word(PROD_W'(im_prod) - PROD_W'($signed(cfg.im_centre)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (pixel.ready) begin
      hold_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      col_q   <= pixel.column;
      row_q   <= pixel.row;
      re_prod <= re_prod_next;
      im_prod <= im_prod_next;
    end
  end

endmodule

// ----- src/mbet_queue.sv -----
// ----------------------------------------------------------------------------
// mbet_queue
// Short FIFO of mapped points between the front and the iteration engine.
// ----------------------------------------------------------------------------
module mbet_queue import mbet_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  point_t push_data,
  input  logic   push_valid,
  output logic   push_ready,
  output point_t pop_data,
  output logic   pop_valid,
  input  logic   pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  point_t           entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/mbet_back.sv -----
// ----------------------------------------------------------------------------
// mbet_back
// Iteration engine: runs z = z^2 + c for one point and emits the count.
// ----------------------------------------------------------------------------
module mbet_back import mbet_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  point_t pop_data,
  input  logic   pop_valid,
  output logic   pop_ready,
  mbet_out_if.source result
);

  localparam logic signed [PROD_W-1:0] FOUR = PROD_W'(4) << FRAC_BITS;

  back_state_e              state;
  back_state_e              state_next;
  logic signed [WORD_W-1:0] zr;
  logic signed [WORD_W-1:0] zi;
  logic signed [WORD_W-1:0] c_re;
  logic signed [WORD_W-1:0] c_im;
  logic [ITER_W-1:0]        n;
  logic [COORD_W-1:0]       col_q;
  logic [COORD_W-1:0]       row_q;
  logic signed [PROD_W-1:0] p_xx;
  logic signed [PROD_W-1:0] p_yy;
  logic signed [PROD_W-1:0] p_xy;
  logic signed [PROD_W-1:0] xx;
  logic signed [PROD_W-1:0] yy;
  logic signed [PROD_W-1:0] xy2;
  logic                     escape;
  logic signed [WORD_W-1:0] zr_next;
  logic signed [WORD_W-1:0] zi_next;
  logic [ITER_W-1:0]        n_inc;
  logic                     out_free;
  logic                     load_res;
  logic                     res_valid;

  // Rescale products (arithmetic shift floors) and form the update
  always_comb begin
    xx      = p_xx >>> FRAC_BITS;
    yy      = p_yy >>> FRAC_BITS;
    xy2     = p_xy >>> (FRAC_BITS - 1);
    escape  = (xx + yy) >= FOUR;
    zr_next = sat_word(xx - yy + PROD_W'(c_re));
    zi_next = sat_word(xy2 + PROD_W'(c_im));
    n_inc   = n + 1'b1;
  end

  assign out_free = !res_valid || result.ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          // a zero limit skips the loop altogether
          state_next = (cfg.max_iter == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_EVAL;
      ST_EVAL: begin
        if (escape || n_inc >= cfg.max_iter) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    pop_ready = (state == ST_IDLE);
    load_res  = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Iteration datapath
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      col_q <= pop_data.column;
      row_q <= pop_data.row;
      c_re  <= pop_data.c_re;
      c_im  <= pop_data.c_im;
      zr    <= '0;
      zi    <= '0;
      n     <= '0;
    end else if (state == ST_MUL) begin
      p_xx <= PROD_W'(zr) * PROD_W'(zr);
      p_yy <= PROD_W'(zi) * PROD_W'(zi);
      p_xy <= PROD_W'(zr) * PROD_W'(zi);
    end else if (state == ST_EVAL && !escape) begin
      zr <= zr_next;
      zi <= zi_next;
      n  <= n_inc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      result.out_column <= col_q;
      result.out_row    <= row_q;
      result.iterations <= n;
      result.inside_res <= (n >= cfg.max_iter);
    end
  end

  assign result.valid = res_valid;

endmodule

// ----- src/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count for one pixel of a Mandelbrot image.
// ----------------------------------------------------------------------------
// Each pixel item is mapped to c (a registered offset-and-scale product,
// then the centre subtracted and clamped) and queued. The iteration engine
// takes a point from the queue in ST_IDLE, then repeats a registered 32x32
// multiply of zr*zr, zi*zi and zr*zi (ST_MUL) and the escape test and
// update (ST_EVAL) until the point escapes or reaches max_iter, whose
// default limit is 50; a zero limit goes straight to ST_DONE, which loads
// the result register. The front keeps mapping and queueing further pixels
// while the engine is busy, until the queue is full; a result still waiting
// in its register holds the engine in its last state until it is taken.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbet_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  mbet_in_if.sink              pixel,
  mbet_out_if.source           result
);

  localparam logic [SPACING_W-1:0] SPACING_RST = SPACING_W'((64'd1 << FRAC_BITS) / SPACING_DIV);
  localparam logic [WORD_W-1:0]    RE_CENTRE_RST = WORD_W'(64'd1 << FRAC_BITS);

  cfg_t   cfg;
  point_t push_data;
  logic   push_valid;
  logic   push_ready;
  point_t pop_data;
  logic   pop_valid;
  logic   pop_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spacing       <= SPACING_RST;
      cfg.re_centre     <= RE_CENTRE_RST;
      cfg.im_centre     <= '0;
      cfg.origin_offset <= OFFSET_W'(OFFSET_RST);
      cfg.max_iter      <= ITER_W'(ITER_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SPACING:   cfg.spacing       <= cfg_data[SPACING_W-1:0];
        REG_RE_CENTRE: cfg.re_centre     <= cfg_data;
        REG_IM_CENTRE: cfg.im_centre     <= cfg_data;
        REG_OFFSET:    cfg.origin_offset <= cfg_data[OFFSET_W-1:0];
        REG_MAX_ITER:  cfg.max_iter      <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  mbet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixel      (pixel),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  mbet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  mbet_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule
